[hw/rtl/spp_pkg.sv]
// Shared types, constants and functions of the stereo pan-law panner.
package spp_pkg;

    localparam int TABLE_ENTRIES_DEF    = 512;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int SAMPLE_BITS_DEF      = 24;

    localparam int POS_W        = 18;
    localparam int CFG_W        = 17;
    localparam int ADDR_W       = 2;
    localparam int POS_ONE      = 65536;
    localparam int STATIC_RST   = 32768;
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W         = 33;
    localparam int Z_W          = 31;
    localparam int FRONT_LAT    = 5;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [28:0]            HALF_PI_Q28 = 29'd421657428;

    localparam logic [1:0] LAW_LINEAR   = 2'd0;
    localparam logic [1:0] LAW_EQ_POWER = 2'd1;
    localparam logic [1:0] LAW_SQRT     = 2'd2;

    localparam logic [ADDR_W-1:0] REG_PAN_LAW    = 2'd0;
    localparam logic [ADDR_W-1:0] REG_PRECISE    = 2'd1;
    localparam logic [ADDR_W-1:0] REG_STATIC_POS = 2'd2;

    typedef struct packed {
        logic [1:0] law;
        logic       take_cos;
        logic       oob;
    } lane_ctl_t;

    typedef struct packed {
        logic item;
        logic refresh;
        logic conn;
    } meta_t;

    function automatic logic [27:0] atan_q28(input int i);
        case (i)
            0:       return 28'd210828714;
            1:       return 28'd124459457;
            2:       return 28'd65760959;
            3:       return 28'd33381290;
            4:       return 28'd16755422;
            5:       return 28'd8385879;
            6:       return 28'd4193963;
            7:       return 28'd2097109;
            8:       return 28'd1048571;
            9:       return 28'd524287;
            10:      return 28'd262144;
            11:      return 28'd131072;
            12:      return 28'd65536;
            13:      return 28'd32768;
            14:      return 28'd16384;
            15:      return 28'd8192;
            16:      return 28'd4096;
            17:      return 28'd2048;
            18:      return 28'd1024;
            19:      return 28'd512;
            20:      return 28'd256;
            21:      return 28'd128;
            22:      return 28'd64;
            23:      return 28'd32;
            default: return 28'd0;
        endcase
    endfunction

    // Q1.16 position to Q.f, rounded half up when f < 16
    function automatic logic [24:0] pos_to_w(input logic [16:0] p, input int f);
        logic [31:0] t;
        t = {15'b0, p};
        if (f >= 16)
            return 25'(t << (f - 16));
        else
            return 25'((t + (32'd1 << (15 - f))) >> (16 - f));
    endfunction

endpackage

[hw/rtl/spp_cell.sv]
// One weight chain cell: a CORDIC rotation step if IDX < CORDIC_STEPS, a square-root digit step if IDX <= F.
module spp_cell #(
    parameter int IDX              = 0,
    parameter int WEIGHT_FRAC_BITS = spp_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [spp_pkg::XY_W-1:0]    x_in,
    input  logic signed [spp_pkg::XY_W-1:0]    y_in,
    input  logic signed [spp_pkg::Z_W-1:0]     z_in,
    input  logic [2*WEIGHT_FRAC_BITS:0]        v_in,
    input  logic [2*WEIGHT_FRAC_BITS+1:0]      r_in,
    input  logic [WEIGHT_FRAC_BITS:0]          u_in,
    input  spp_pkg::lane_ctl_t                 ctl_in,
    output logic signed [spp_pkg::XY_W-1:0]    x_out,
    output logic signed [spp_pkg::XY_W-1:0]    y_out,
    output logic signed [spp_pkg::Z_W-1:0]     z_out,
    output logic [2*WEIGHT_FRAC_BITS:0]        v_out,
    output logic [2*WEIGHT_FRAC_BITS+1:0]      r_out,
    output logic [WEIGHT_FRAC_BITS:0]          u_out,
    output spp_pkg::lane_ctl_t                 ctl_out
);
    import spp_pkg::*;

    localparam int F   = WEIGHT_FRAC_BITS;
    localparam int V_W = 2*F + 1;
    localparam int R_W = 2*F + 2;

    logic signed [XY_W-1:0] x_next, y_next;
    logic signed [Z_W-1:0]  z_next;
    logic [V_W-1:0]         v_next;
    logic [R_W-1:0]         r_next;
    logic [R_W-1:0]         bitv, trial;
    logic signed [Z_W-1:0]  atan_v;

    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [V_W-1:0]         v_reg;
    logic [R_W-1:0]         r_reg;
    logic [F:0]             u_reg;
    lane_ctl_t              ctl_reg;

    always_comb
    begin
        atan_v = signed'({3'b0, atan_q28(IDX)});
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        if (IDX < CORDIC_STEPS)
        begin
            if (z_in >= 0)
            begin
                x_next = x_in - (y_in >>> IDX);
                y_next = y_in + (x_in >>> IDX);
                z_next = z_in - atan_v;
            end
            else
            begin
                x_next = x_in + (y_in >>> IDX);
                y_next = y_in - (x_in >>> IDX);
                z_next = z_in + atan_v;
            end
        end
    end

    always_comb
    begin
        bitv   = R_W'(1) << (2*(F - IDX));
        trial  = r_in + bitv;
        v_next = v_in;
        r_next = r_in;
        if (IDX <= F)
        begin
            if ({1'b0, v_in} >= trial)
            begin
                v_next = V_W'(({1'b0, v_in}) - trial);
                r_next = (r_in >> 1) + bitv;
            end
            else
            begin
                r_next = r_in >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            v_reg   <= v_next;
            r_reg   <= r_next;
            u_reg   <= u_in;
            ctl_reg <= ctl_in;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign v_out   = v_reg;
    assign r_out   = r_reg;
    assign u_out   = u_reg;
    assign ctl_out = ctl_reg;

endmodule

[hw/rtl/spp_lane.sv]
// Weight lane: angle scaling, chain of CORDIC/root cells and final rounding/selection.
module spp_lane #(
    parameter int WEIGHT_FRAC_BITS = spp_pkg::WEIGHT_FRAC_BITS_DEF,
    parameter int N_CELLS          = spp_pkg::CORDIC_STEPS
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [WEIGHT_FRAC_BITS:0] u_in,
    input  spp_pkg::lane_ctl_t        ctl_in,
    output logic [WEIGHT_FRAC_BITS:0] w_out
);
    import spp_pkg::*;

    localparam int F    = WEIGHT_FRAC_BITS;
    localparam int V_W  = 2*F + 1;
    localparam int R_W  = 2*F + 2;
    localparam int M_W  = F + 30;
    localparam int SH   = 30 - F;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic signed [XY_W-1:0] x_c [N_CELLS+1];
    logic signed [XY_W-1:0] y_c [N_CELLS+1];
    logic signed [Z_W-1:0]  z_c [N_CELLS+1];
    logic [V_W-1:0]         v_c [N_CELLS+1];
    logic [R_W-1:0]         r_c [N_CELLS+1];
    logic [F:0]             u_c [N_CELLS+1];
    lane_ctl_t              ctl_c [N_CELLS+1];

    logic [M_W-1:0] zprod;
    logic signed [Z_W-1:0] z_reg;
    logic [F:0]     u_reg;
    lane_ctl_t      ctl_reg;

    logic signed [XY_W:0] xr, yr;
    logic [F:0]     c_w, s_w, q_w, w_next, w_reg;
    logic [R_W-1:0] root;

    assign zprod = (M_W'(u_in) * M_W'(HALF_PI_Q28) + (M_W'(1) << (F - 1))) >> F;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg   <= Z_W'(zprod);
            u_reg   <= u_in;
            ctl_reg <= ctl_in;
        end
    end

    assign x_c[0]   = CORDIC_GAIN;
    assign y_c[0]   = '0;
    assign z_c[0]   = z_reg;
    assign v_c[0]   = {u_reg, {F{1'b0}}};
    assign r_c[0]   = '0;
    assign u_c[0]   = u_reg;
    assign ctl_c[0] = ctl_reg;

    for (genvar g = 0; g < N_CELLS; g++)
    begin : g_cell
        spp_cell #(
            .IDX              (g),
            .WEIGHT_FRAC_BITS (F)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .x_in    (x_c[g]),
            .y_in    (y_c[g]),
            .z_in    (z_c[g]),
            .v_in    (v_c[g]),
            .r_in    (r_c[g]),
            .u_in    (u_c[g]),
            .ctl_in  (ctl_c[g]),
            .x_out   (x_c[g+1]),
            .y_out   (y_c[g+1]),
            .z_out   (z_c[g+1]),
            .v_out   (v_c[g+1]),
            .r_out   (r_c[g+1]),
            .u_out   (u_c[g+1]),
            .ctl_out (ctl_c[g+1])
        );
    end

    always_comb
    begin
        xr = ((XY_W+1)'(x_c[N_CELLS]) + (XY_W+1)'(1 << (SH - 1))) >>> SH;
        yr = ((XY_W+1)'(y_c[N_CELLS]) + (XY_W+1)'(1 << (SH - 1))) >>> SH;
        if (xr < 0)
            c_w = '0;
        else if (xr > signed'((XY_W+1)'(ONE)))
            c_w = ONE;
        else
            c_w = xr[F:0];
        if (yr < 0)
            s_w = '0;
        else if (yr > signed'((XY_W+1)'(ONE)))
            s_w = ONE;
        else
            s_w = yr[F:0];
        root = r_c[N_CELLS] + R_W'({1'b0, v_c[N_CELLS]} > r_c[N_CELLS]);
        q_w  = root[F:0];
        case (ctl_c[N_CELLS].law)
            LAW_EQ_POWER: w_next = ctl_c[N_CELLS].take_cos ? c_w : s_w;
            LAW_SQRT:     w_next = q_w;
            default:      w_next = u_c[N_CELLS];
        endcase
        if (ctl_c[N_CELLS].oob)
            w_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            w_reg <= w_next;
    end

    assign w_out = w_reg;

endmodule

[hw/rtl/spp_front.sv]
// Position front end: range check, table index and grid position, lane operands.
module spp_front #(
    parameter int TABLE_ENTRIES    = spp_pkg::TABLE_ENTRIES_DEF,
    parameter int WEIGHT_FRAC_BITS = spp_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [spp_pkg::POS_W-1:0]    pos_in,
    input  logic [1:0]                          law_in,
    input  logic                                precise_in,
    output logic [WEIGHT_FRAC_BITS:0]           u_left,
    output logic [WEIGHT_FRAC_BITS:0]           u_right,
    output spp_pkg::lane_ctl_t                  ctl_left,
    output spp_pkg::lane_ctl_t                  ctl_right
);
    import spp_pkg::*;

    localparam int F     = WEIGHT_FRAC_BITS;
    localparam int N1    = TABLE_ENTRIES - 1;
    localparam int IW    = $clog2(TABLE_ENTRIES);
    localparam int DIV   = 2 * N1;
    localparam int NUM_W = IW + 18;
    localparam int RW    = NUM_W + 1 - $clog2(DIV);
    localparam int QP_W  = NUM_W + RW;
    localparam longint RECIP = (longint'(1) << NUM_W) / DIV;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // stage 1
    logic signed [POS_W-1:0] p_reg;
    logic [1:0] law1_reg;
    logic       prec1_reg;
    logic       oob1;
    logic [16:0] pu, dpos;
    logic [17:0] diff;
    logic [16+IW:0] prod_a, prod_b;
    logic [24:0] pw_full1;

    // stage 2
    logic [IW-1:0] i1_reg, i2_reg;
    logic [F:0]    pw2_reg;
    logic          oob2_reg, prec2_reg;
    logic [1:0]    law2_reg;
    logic [NUM_W-1:0] num1, num2;
    logic [QP_W-1:0]  qp1, qp2;

    // stage 3
    logic [NUM_W-1:0] num1_reg, num2_reg;
    logic [17:0]      qe1_reg, qe2_reg;
    logic [F:0]       pw3_reg;
    logic             oob3_reg, prec3_reg;
    logic [1:0]       law3_reg;
    logic [NUM_W+17:0] m1, m2;
    logic [NUM_W-1:0]  rem1, rem2;
    logic [17:0]       q1, q2;

    // stage 4
    logic [16:0] q1_reg, q2_reg;
    logic [F:0]  pw4_reg;
    logic        oob4_reg, prec4_reg;
    logic [1:0]  law4_reg;
    logic [1:0]  law_n;
    logic [24:0] wq1, wq2;

    // stage 5
    logic [F:0] ul_reg, ur_reg;
    lane_ctl_t  cl_reg, cr_reg;
    logic [F:0] ul_next, ur_next;
    logic       cos_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= pos_in;
            law1_reg  <= law_in;
            prec1_reg <= precise_in;
        end
    end

    always_comb
    begin
        oob1     = (p_reg < 0) || (p_reg > signed'(POS_W'(POS_ONE)));
        pu       = p_reg[16:0];
        diff     = 18'(POS_ONE) - {1'b0, pu};
        dpos     = diff[16:0];
        prod_a   = (17+IW)'(dpos) * (17+IW)'(N1);
        prod_b   = (17+IW)'(pu) * (17+IW)'(N1);
        pw_full1 = pos_to_w(pu, F);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i1_reg    <= prod_a[15+IW:16];
            i2_reg    <= prod_b[15+IW:16];
            pw2_reg   <= pw_full1[F:0];
            oob2_reg  <= oob1;
            prec2_reg <= prec1_reg;
            law2_reg  <= law1_reg;
        end
    end

    // grid position round(i * 65536 / N1) by reciprocal multiply
    always_comb
    begin
        num1 = {1'b0, i1_reg, 17'b0} + NUM_W'(N1);
        num2 = {1'b0, i2_reg, 17'b0} + NUM_W'(N1);
        qp1  = QP_W'(num1) * QP_W'(RECIP);
        qp2  = QP_W'(num2) * QP_W'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg  <= num1;
            num2_reg  <= num2;
            qe1_reg   <= qp1[NUM_W +: 18];
            qe2_reg   <= qp2[NUM_W +: 18];
            pw3_reg   <= pw2_reg;
            oob3_reg  <= oob2_reg;
            prec3_reg <= prec2_reg;
            law3_reg  <= law2_reg;
        end
    end

    always_comb
    begin
        m1   = (NUM_W+18)'(qe1_reg) * (NUM_W+18)'(DIV);
        m2   = (NUM_W+18)'(qe2_reg) * (NUM_W+18)'(DIV);
        rem1 = num1_reg - m1[NUM_W-1:0];
        rem2 = num2_reg - m2[NUM_W-1:0];
        q1   = (rem1 >= NUM_W'(DIV)) ? qe1_reg + 18'd1 : qe1_reg;
        q2   = (rem2 >= NUM_W'(DIV)) ? qe2_reg + 18'd1 : qe2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg    <= q1[16:0];
            q2_reg    <= q2[16:0];
            pw4_reg   <= pw3_reg;
            oob4_reg  <= oob3_reg;
            prec4_reg <= prec3_reg;
            law4_reg  <= law3_reg;
        end
    end

    always_comb
    begin
        case (law4_reg)
            LAW_EQ_POWER: law_n = LAW_EQ_POWER;
            LAW_SQRT:     law_n = LAW_SQRT;
            default:      law_n = LAW_LINEAR;
        endcase
        wq1 = pos_to_w(q1_reg, F);
        wq2 = pos_to_w(q2_reg, F);
        if (prec4_reg)
        begin
            cos_next = (law_n == LAW_EQ_POWER);
            ul_next  = cos_next ? pw4_reg : ONE - pw4_reg;
            ur_next  = pw4_reg;
        end
        else
        begin
            cos_next = 1'b0;
            ul_next  = wq1[F:0];
            ur_next  = wq2[F:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ul_reg <= ul_next;
            ur_reg <= ur_next;
            cl_reg <= '{law: law_n, take_cos: cos_next, oob: oob4_reg};
            cr_reg <= '{law: law_n, take_cos: 1'b0, oob: oob4_reg};
        end
    end

    assign u_left    = ul_reg;
    assign u_right   = ur_reg;
    assign ctl_left  = cl_reg;
    assign ctl_right = cr_reg;

endmodule

[hw/rtl/stereo_pan_law_panner_top.sv]
// Top level of the stereo pan-law panner: config registers, weight lanes, scaling, output.
//
// One mono sample in, one left/right pair out, one request per clock sustained while the
// output is not back-pressured and no refresh holds the input off. The CORDIC/root cell
// chain in each lane is N_CELLS = max(24, WEIGHT_FRAC_BITS+1) cells long. Both weights
// are computed for every request in either mode; table mode evaluates the table entry at its
// grid position through the same cells. After reset and after every write to one of the
// three config registers the input is held off while a refresh of the cached static-position
// weights enters the pipeline; requests with position_connected low that follow it see the
// new weights. A back-pressured output stalls the whole pipeline.
module stereo_pan_law_panner_top #(
    parameter int TABLE_ENTRIES    = spp_pkg::TABLE_ENTRIES_DEF,
    parameter int WEIGHT_FRAC_BITS = spp_pkg::WEIGHT_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS      = spp_pkg::SAMPLE_BITS_DEF,
    parameter int TD_IN_W  = ((SAMPLE_BITS + spp_pkg::POS_W + 7) / 8) * 8,
    parameter int TD_OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [TD_IN_W-1:0]          s_tdata,   // audio_in, position_signal, zero pad
    input  logic                        s_tuser,   // position_connected
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [TD_OUT_W-1:0]         m_tdata,   // left_out, right_out, zero pad
    input  logic                        cfg_we,
    input  logic [spp_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [spp_pkg::CFG_W-1:0]   cfg_data
);
    import spp_pkg::*;

    localparam int F       = WEIGHT_FRAC_BITS;
    localparam int S       = SAMPLE_BITS;
    localparam int N_CELLS = (CORDIC_STEPS > F + 1) ? CORDIC_STEPS : F + 1;
    localparam int META_D  = FRONT_LAT + N_CELLS + 2;
    localparam int P_W     = S + F + 2;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic signed [P_W:0] HI = (P_W+1)'((longint'(1) << (S - 1)) - 1);
    localparam logic signed [P_W:0] LO = -HI - 1;

    logic [1:0]       law_reg;
    logic             precise_reg;
    logic [CFG_W-1:0] static_reg;
    logic             pend_reg, pend_next;
    logic             en, accept, cfg_hit;

    logic signed [S-1:0]     smp_in;
    logic signed [POS_W-1:0] pos_sig, pos_entry;

    meta_t             meta_reg [META_D];
    logic signed [S-1:0] samp_reg [META_D];

    logic [F:0] u_l, u_r, w_l, w_r;
    lane_ctl_t  c_l, c_r;
    logic [F:0] cache_l_reg, cache_r_reg;
    logic [F:0] sel_l, sel_r;

    logic signed [P_W-1:0] prod_l_reg, prod_r_reg;
    logic                  item_m_reg;
    logic signed [P_W:0]   rnd_l, rnd_r;
    logic signed [S-1:0]   sat_l, sat_r;
    logic signed [S-1:0]   out_l_reg, out_r_reg;
    logic                  out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en && !pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign cfg_hit  = cfg_we && (cfg_addr == REG_PAN_LAW || cfg_addr == REG_PRECISE ||
                                 cfg_addr == REG_STATIC_POS);

    assign smp_in  = s_tdata[S-1:0];
    assign pos_sig = s_tdata[S +: POS_W];
    assign pos_entry = (pend_reg || !s_tuser) ? signed'({1'b0, static_reg}) : pos_sig;

    always_comb
    begin
        pend_next = pend_reg;
        if (cfg_hit)
            pend_next = 1'b1;
        else if (en)
            pend_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_reg     <= LAW_EQ_POWER;
            precise_reg <= 1'b0;
            static_reg  <= CFG_W'(STATIC_RST);
            pend_reg    <= 1'b1;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_PAN_LAW:    law_reg     <= cfg_data[1:0];
                    REG_PRECISE:    precise_reg <= cfg_data[0];
                    REG_STATIC_POS: static_reg  <= (cfg_data > CFG_W'(POS_ONE)) ?
                                                   CFG_W'(POS_ONE) : cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    spp_front #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .WEIGHT_FRAC_BITS (F)
    ) u_front (
        .clk        (clk),
        .en         (en),
        .pos_in     (pos_entry),
        .law_in     (law_reg),
        .precise_in (precise_reg),
        .u_left     (u_l),
        .u_right    (u_r),
        .ctl_left   (c_l),
        .ctl_right  (c_r)
    );

    spp_lane #(
        .WEIGHT_FRAC_BITS (F),
        .N_CELLS          (N_CELLS)
    ) u_lane_l (
        .clk    (clk),
        .en     (en),
        .u_in   (u_l),
        .ctl_in (c_l),
        .w_out  (w_l)
    );

    spp_lane #(
        .WEIGHT_FRAC_BITS (F),
        .N_CELLS          (N_CELLS)
    ) u_lane_r (
        .clk    (clk),
        .en     (en),
        .u_in   (u_r),
        .ctl_in (c_r),
        .w_out  (w_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < META_D; i++)
                meta_reg[i] <= '0;
            item_m_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            meta_reg[0] <= '{item: accept, refresh: pend_reg, conn: s_tuser};
            for (int i = 1; i < META_D; i++)
                meta_reg[i] <= meta_reg[i-1];
            item_m_reg    <= meta_reg[META_D-1].item;
            out_valid_reg <= item_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            samp_reg[0] <= smp_in;
            for (int i = 1; i < META_D; i++)
                samp_reg[i] <= samp_reg[i-1];
            if (meta_reg[META_D-1].refresh)
            begin
                cache_l_reg <= w_l;
                cache_r_reg <= w_r;
            end
            prod_l_reg <= P_W'(samp_reg[META_D-1]) * signed'(P_W'(sel_l));
            prod_r_reg <= P_W'(samp_reg[META_D-1]) * signed'(P_W'(sel_r));
            out_l_reg  <= sat_l;
            out_r_reg  <= sat_r;
        end
    end

    assign sel_l = meta_reg[META_D-1].conn ? w_l : cache_l_reg;
    assign sel_r = meta_reg[META_D-1].conn ? w_r : cache_r_reg;

    always_comb
    begin
        rnd_l = ((P_W+1)'(prod_l_reg) + (P_W+1)'(1 << (F - 1))) >>> F;
        rnd_r = ((P_W+1)'(prod_r_reg) + (P_W+1)'(1 << (F - 1))) >>> F;
        if (rnd_l > HI)
            sat_l = HI[S-1:0];
        else if (rnd_l < LO)
            sat_l = LO[S-1:0];
        else
            sat_l = rnd_l[S-1:0];
        if (rnd_r > HI)
            sat_r = HI[S-1:0];
        else if (rnd_r < LO)
            sat_r = LO[S-1:0];
        else
            sat_r = rnd_r[S-1:0];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TD_OUT_W'({out_r_reg, out_l_reg});

    a_refresh_not_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(meta_reg[META_D-1].item && meta_reg[META_D-1].refresh))
        else $error("refresh slot carries a request");

    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !s_tready)
        else $error("input taken before cached weights refresh entered");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (meta_reg[META_D-1].item || meta_reg[META_D-1].refresh) |-> (w_l <= ONE && w_r <= ONE))
        else $error("lane weight above one");

endmodule

[sim/tb_stereo_pan_law_panner_top.sv]
// Self-checking testbench of the stereo pan-law panner: directed and random stream traffic against a predictor.
module tb_stereo_pan_law_panner_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spp_pkg::*;

    localparam int N1 = 511;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 80;

    typedef struct packed {
        logic        conn;
        logic [17:0] pos;
        logic [23:0] smp;
    } req_t;

    typedef struct packed {
        logic [23:0] right;
        logic [23:0] left;
    } pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    stereo_pan_law_panner_top DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [1:0] law_q;
    logic prec_q;
    longint stat_q, cache_l, cache_r;
    req_t pending_reqs[$];
    pair_t expected_pairs[$];
    int errors = 0;
    int idle_cycles = 0;
    bit drv_busy = 0;

    longint atan_tab[24] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
        2048, 1024, 512, 256, 128, 64, 32};

    function automatic longint q30_w(longint v);
        longint r;
        r = (v + (64'sd1 <<< 13)) >>> 14;
        if (r < 0) r = 0;
        if (r > 65536) r = 65536;
        return r;
    endfunction

    function automatic longint isqrt_rnd(longint v0);
        longint unsigned v, r, b;
        v = v0; r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        if (v > r) r++;
        return longint'(r);
    endfunction

    function automatic void cordic_cs(longint pw, output longint c, output longint s);
        longint x, y, z, nx;
        x = 652032874; y = 0;
        z = (pw * 421657428 + 32768) >>> 16;
        for (int i = 0; i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
            end
            x = nx;
        end
        c = q30_w(x);
        s = q30_w(y);
    endfunction

    function automatic longint grid_weight(logic [1:0] law, longint idx);
        longint q, c, s;
        q = (idx * 65536 * 2 + N1) / (2 * N1);
        if (law == LAW_EQ_POWER)
        begin
            cordic_cs(q, c, s);
            return s;
        end
        if (law == LAW_SQRT) return isqrt_rnd(q << 16);
        return q;
    endfunction

    function automatic void pan_weights(longint p, output longint w1, output longint w2);
        longint c, s;
        w1 = 0; w2 = 0;
        if (p < 0 || p > 65536) return;
        if (!prec_q)
        begin
            w1 = grid_weight(law_q, ((65536 - p) * N1) >>> 16);
            w2 = grid_weight(law_q, (p * N1) >>> 16);
        end
        else if (law_q == LAW_EQ_POWER)
        begin
            cordic_cs(p, c, s);
            w1 = c; w2 = s;
        end
        else if (law_q == LAW_SQRT)
        begin
            w1 = isqrt_rnd((65536 - p) << 16);
            w2 = isqrt_rnd(p << 16);
        end
        else
        begin
            w1 = 65536 - p; w2 = p;
        end
    endfunction

    function automatic logic [23:0] scale_sat(longint smp, longint w);
        longint v;
        v = (smp * w + 32768) >>> 16;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function automatic pair_t predict_pair(req_t r);
        longint w1, w2;
        pair_t o;
        w1 = cache_l; w2 = cache_r;
        if (r.conn) pan_weights(longint'($signed(r.pos)), w1, w2);
        o.left = scale_sat(longint'($signed(r.smp)), w1);
        o.right = scale_sat(longint'($signed(r.smp)), w2);
        return o;
    endfunction

    task automatic write_reg(logic [ADDR_W-1:0] a, logic [CFG_W-1:0] d);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_addr <= a; cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (a == REG_PAN_LAW) law_q = d[1:0];
        else if (a == REG_PRECISE) prec_q = d[0];
        else if (a == REG_STATIC_POS) stat_q = (d > 65536) ? 65536 : d;
        pan_weights(stat_q, cache_l, cache_r);
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_reqs.size() != 0 || drv_busy || s_tvalid || expected_pairs.size() != 0);
        repeat (DRAIN) @(negedge clk);
    endtask

    function automatic req_t rand_req();
        req_t r;
        int k;
        r.smp = 24'($urandom);
        r.conn = ($urandom_range(0, 3) != 0);
        k = $urandom_range(0, 9);
        if (k == 0) r.pos = 18'($urandom);
        else if (k == 1) r.pos = 18'(65536 + $urandom_range(0, 3) - 1);
        else if (k == 2) r.pos = 18'($urandom_range(0, 2));
        else r.pos = 18'($urandom_range(0, 65536));
        if ($urandom_range(0, 7) == 0) r.smp = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        return r;
    endfunction

    function automatic req_t mk(logic [23:0] s, logic [17:0] p, logic c);
        req_t r;
        r.smp = s; r.pos = p; r.conn = c;
        return r;
    endfunction

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge clk)
    begin
        if (s_tvalid && !s_tready)
        begin
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
            drv_busy <= 0;
        end
        else if (pending_reqs.size() > 0)
        begin
            req_t r;
            r = pending_reqs.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= {6'b0, r.pos, r.smp};
            s_tuser <= r.conn;
            drv_busy <= 1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
        begin
            s_tvalid <= 1'b0;
            drv_busy <= 0;
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[9:8] == 2'd0) m_tready <= 1'b1;
        else if (stall_phase[9:8] == 2'd1) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= ($urandom_range(0, 2) == 0) ? 1'b0 : stall_phase[2];
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_pairs.push_back(predict_pair(req_t'({s_tuser, s_tdata[41:0]})));
            if (m_tvalid && m_tready)
            begin
                pair_t e, a;
                a = m_tdata;
                if (expected_pairs.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected output %h", $time, a);
                end
                else
                begin
                    e = expected_pairs.pop_front();
                    if (e.left !== a.left)
                    begin
                        errors++;
                        $display("%0t left exp %h got %h", $time, e.left, a.left);
                    end
                    if (e.right !== a.right)
                    begin
                        errors++;
                        $display("%0t right exp %h got %h", $time, e.right, a.right);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        law_q = LAW_EQ_POWER; prec_q = 0; stat_q = STATIC_RST;
        pan_weights(stat_q, cache_l, cache_r);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);
        // directed
        for (int m = 0; m < 2; m++)
        begin
            write_reg(REG_PRECISE, m[CFG_W-1:0]);
            for (int l = 0; l < 4; l++)
            begin
                write_reg(REG_PAN_LAW, l[CFG_W-1:0]);
                pending_reqs.push_back(mk(24'h7FFFFF, 18'd0, 1'b1));
                pending_reqs.push_back(mk(24'h800000, 18'd65536, 1'b1));
                pending_reqs.push_back(mk(24'h7FFFFF, 18'd32768, 1'b1));
                pending_reqs.push_back(mk(24'h800000, 18'h3FFFF, 1'b1));
                pending_reqs.push_back(mk(24'h123456, 18'd65537, 1'b1));
                pending_reqs.push_back(mk(24'h7FFFFF, 18'h20000, 1'b0));
                wait_drained();
            end
        end
        write_reg(REG_STATIC_POS, 17'h1FFFF);
        pending_reqs.push_back(mk(24'h7FFFFF, 18'd0, 1'b0));
        wait_drained();
        write_reg(ADDR_W'(3), 17'd5);
        // random phases
        for (int ph = 0; ph < 15; ph++)
        begin
            write_reg(REG_PAN_LAW, CFG_W'($urandom_range(0, 3)));
            write_reg(REG_PRECISE, CFG_W'($urandom));
            case (ph % 4)
                0: write_reg(REG_STATIC_POS, 17'd0);
                1: write_reg(REG_STATIC_POS, 17'd65536);
                default: write_reg(REG_STATIC_POS, CFG_W'($urandom));
            endcase
            for (int i = 0; i < 100; i++) pending_reqs.push_back(rand_req());
            wait_drained();
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
